@@ rtl/core/psb_pkg.sv @@
// Shared types, constants and remap tables of the palette sprite blitter.
`timescale 1ns / 1ps
`default_nettype none

package psb_pkg;

   // Default geometry of the tiled map.
   localparam int DEF_TILE_W   = 24;
   localparam int DEF_TILE_H   = 24;
   localparam int DEF_MAP_COLS = 64;
   localparam int DEF_MAP_ROWS = 64;

   // Field widths.
   localparam int TILE_IDX_W = 6;
   localparam int SIZE_W     = 8;
   localparam int INDEX_W    = 8;
   localparam int CHAN_IN_W  = 6;
   localparam int CHAN_OUT_W = 8;
   localparam int ADDR_W     = 22;
   localparam int RGB_W      = 3 * CHAN_OUT_W;
   localparam int SEL_W      = 2;

   // Signed width of a pixel coordinate, enough for the largest image and offsets.
   localparam int POS_W = 15;

   // Palette memory.
   localparam int PAL_DEPTH = 256;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_TILE_X         = 3'd0,
      REG_TILE_Y         = 3'd1,
      REG_SPRITE_WIDTH   = 3'd2,
      REG_SPRITE_HEIGHT  = 3'd3,
      REG_CENTERED       = 3'd4,
      REG_PALETTE_SELECT = 3'd5
   } csr_index_type;

   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_PIXEL   = 1'b1;

   localparam logic [SEL_W-1:0] PAL_BASE      = 2'd0;
   localparam logic [SEL_W-1:0] PAL_STRUCTURE = 2'd1;
   localparam logic [SEL_W-1:0] PAL_UNIT      = 2'd2;

   localparam logic [INDEX_W-1:0] CLEAR_INDEX_A = 8'h00;
   localparam logic [INDEX_W-1:0] CLEAR_INDEX_B = 8'h04;
   localparam logic [3:0]         REMAP_BANK    = 4'hB;  // indices 176 to 191

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] pixel_address;
   } place_result_type;

   function automatic logic [INDEX_W-1:0] structure_entry(input logic [3:0] k);
      logic [INDEX_W-1:0] v;
      case (k)
         4'd0:  v = 8'h7f;
         4'd1:  v = 8'h7e;
         4'd2:  v = 8'h7d;
         4'd3:  v = 8'h7c;
         4'd4:  v = 8'h7a;
         4'd5:  v = 8'h2e;
         4'd6:  v = 8'h78;
         4'd7:  v = 8'h2f;
         4'd8:  v = 8'h7d;
         4'd9:  v = 8'h7c;
         4'd10: v = 8'h7b;
         4'd11: v = 8'h7a;
         4'd12: v = 8'h2a;
         4'd13: v = 8'h79;
         4'd14: v = 8'h78;
         default: v = 8'h78;
      endcase
      return v;
   endfunction

   function automatic logic [INDEX_W-1:0] unit_entry(input logic [3:0] k);
      logic [INDEX_W-1:0] v;
      case (k)
         4'd0:  v = 8'ha1;
         4'd1:  v = 8'hc8;
         4'd2:  v = 8'hc9;
         4'd3:  v = 8'hca;
         4'd4:  v = 8'hcc;
         4'd5:  v = 8'hcd;
         4'd6:  v = 8'hce;
         4'd7:  v = 8'h0c;
         4'd8:  v = 8'hc9;
         4'd9:  v = 8'hca;
         4'd10: v = 8'hcb;
         4'd11: v = 8'hcc;
         4'd12: v = 8'hcd;
         4'd13: v = 8'h73;
         4'd14: v = 8'hc6;
         default: v = 8'h72;
      endcase
      return v;
   endfunction

   // Palette slot actually read for a colour index under the given palette select.
   function automatic logic [INDEX_W-1:0] remap_index(input logic [INDEX_W-1:0] idx,
                                                      input logic [SEL_W-1:0]   sel);
      logic [INDEX_W-1:0] slot;
      slot = idx;
      if (idx[7:4] == REMAP_BANK) begin
         if (sel == PAL_STRUCTURE) begin
            slot = structure_entry(idx[3:0]);
         end else if (sel == PAL_UNIT) begin
            slot = unit_entry(idx[3:0]);
         end
      end
      return slot;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/psb_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module psb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/psb_place.sv @@
// Sprite origin registers and placement of one pixel into the map image.
`timescale 1ns / 1ps
`default_nettype none

module psb_place #(
   parameter int TILE_W   = psb_pkg::DEF_TILE_W,
   parameter int TILE_H   = psb_pkg::DEF_TILE_H,
   parameter int MAP_COLS = psb_pkg::DEF_MAP_COLS,
   parameter int MAP_ROWS = psb_pkg::DEF_MAP_ROWS
) (
   input  wire logic                                clock,
   input  wire logic [psb_pkg::TILE_IDX_W-1:0]      tile_x,
   input  wire logic [psb_pkg::TILE_IDX_W-1:0]      tile_y,
   input  wire logic [psb_pkg::SIZE_W-1:0]          sprite_width,
   input  wire logic [psb_pkg::SIZE_W-1:0]          sprite_height,
   input  wire logic                                centered,
   input  wire logic [psb_pkg::SIZE_W-1:0]          column,
   input  wire logic [psb_pkg::SIZE_W-1:0]          row,
   input  wire logic [psb_pkg::INDEX_W-1:0]         colour_index,
   output psb_pkg::place_result_type                result
);
   import psb_pkg::*;

   localparam int IMG_W  = MAP_COLS * TILE_W;
   localparam int IMG_H  = MAP_ROWS * TILE_H;
   localparam int PROD_W = 2 * POS_W;

   logic [POS_W-1:0] base_x;
   logic [POS_W-1:0] base_y;
   logic [POS_W-1:0] org_x_in;
   logic [POS_W-1:0] org_y_in;
   logic [POS_W-1:0] org_x_ff;
   logic [POS_W-1:0] org_y_ff;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic             on_image;
   logic             opaque;
   logic [PROD_W-1:0] linear;

   // Origin tracks config; user must write it only while idle; unchecked.
   always_comb begin
      base_x = POS_W'(tile_x) * POS_W'(TILE_W);
      base_y = POS_W'(tile_y) * POS_W'(TILE_H);
      if (centered) begin
         org_x_in = base_x - POS_W'(sprite_width >> 1) + POS_W'(TILE_W / 2);
         org_y_in = base_y - POS_W'(sprite_height >> 1) + POS_W'(TILE_H / 2);
      end else begin
         org_x_in = base_x;
         org_y_in = base_y;
      end
   end

   always_ff @(posedge clock) begin
      org_x_ff <= org_x_in;
      org_y_ff <= org_y_in;
   end

   always_comb begin
      pos_x    = org_x_ff + POS_W'(column);
      pos_y    = org_y_ff + POS_W'(row);
      on_image = !pos_x[POS_W-1] && (pos_x < POS_W'(IMG_W)) &&
                 !pos_y[POS_W-1] && (pos_y < POS_W'(IMG_H));
      opaque   = (colour_index != CLEAR_INDEX_A) && (colour_index != CLEAR_INDEX_B);
      linear   = PROD_W'(pos_y) * PROD_W'(IMG_W) + PROD_W'(pos_x);
      result.write_enable  = on_image && opaque;
      result.pixel_address = (on_image && opaque) ? linear[ADDR_W-1:0] : '0;
   end

endmodule

`default_nettype wire

@@ rtl/core/palette_sprite_blitter_core.sv @@
// Top level of the color-keyed palette sprite blitter.
//
// Usage: items enter on the req_ channel (valid/stall). An item with opcode
// palette write stores a 6-bit RGB entry, widened to 8 bits per channel, and
// produces no result. An item with opcode pixel carries one sprite color index;
// pixels arrive in raster order and the block counts column and row itself.
// Each pixel produces exactly one result item on the rsp_ channel: a write
// flag, the linear pixel address in the map image, the 8-bit RGB color and a
// flag on the final pixel of the sprite. Transparent or off-image pixels come
// out with the write flag low and address and color zero.
// Throughput is one item per cycle while the receiver does not stall. A pixel
// passes the placement stage, which reads the palette memory, whose read port is
// registered, and places the pixel, then the output register. A stalled receiver
// first fills the output register, then the placement stage; only then is
// req_stall raised. Reset clears the counters and all valid flags and restores
// the configuration defaults; the palette memory keeps its contents and an entry
// must be written before a pixel uses it. Configuration goes through the
// APB-style csr_ port only while idle, a user duty the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module palette_sprite_blitter_core #(
   parameter int TILE_W   = psb_pkg::DEF_TILE_W,
   parameter int TILE_H   = psb_pkg::DEF_TILE_H,
   parameter int MAP_COLS = psb_pkg::DEF_MAP_COLS,
   parameter int MAP_ROWS = psb_pkg::DEF_MAP_ROWS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input item channel.
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_opcode,
   input  wire logic [psb_pkg::INDEX_W-1:0]         req_colour_index,
   input  wire logic [psb_pkg::CHAN_IN_W-1:0]       req_red_in,
   input  wire logic [psb_pkg::CHAN_IN_W-1:0]       req_green_in,
   input  wire logic [psb_pkg::CHAN_IN_W-1:0]       req_blue_in,
   // Result item channel.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_write_enable,
   output logic      [psb_pkg::ADDR_W-1:0]          rsp_pixel_address,
   output logic      [psb_pkg::CHAN_OUT_W-1:0]      rsp_red_out,
   output logic      [psb_pkg::CHAN_OUT_W-1:0]      rsp_green_out,
   output logic      [psb_pkg::CHAN_OUT_W-1:0]      rsp_blue_out,
   output logic                                     rsp_last_pixel,
   // Configuration port.
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [psb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [psb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [psb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                     csr_pready
);
   import psb_pkg::*;

   localparam int PAL_ADDR_W = $clog2(PAL_DEPTH);

   // Configuration registers.
   logic [TILE_IDX_W-1:0] tile_x_ff;
   logic [TILE_IDX_W-1:0] tile_y_ff;
   logic [SIZE_W-1:0]     sprite_width_ff;
   logic [SIZE_W-1:0]     sprite_height_ff;
   logic                  centered_ff;
   logic [SEL_W-1:0]      palette_select_ff;
   logic                  csr_write;
   csr_index_type         csr_index;

   // Raster counters.
   logic [SIZE_W-1:0] col_ff;
   logic [SIZE_W-1:0] col_in;
   logic [SIZE_W-1:0] row_ff;
   logic [SIZE_W-1:0] row_in;
   logic [SIZE_W-1:0] width_m1;
   logic [SIZE_W-1:0] height_m1;
   logic              col_end;
   logic              row_end;
   logic              last_in;

   // Handshake and pipeline control.
   logic req_accept;
   logic pixel_accept;
   logic stage_adv;
   logic out_load;

   // Placement stage.
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [SIZE_W-1:0]  s1_col_ff;
   logic [SIZE_W-1:0]  s1_row_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic               s1_last_ff;
   place_result_type   place;

   // Palette memory.
   logic                  pal_wr_en;
   logic [RGB_W-1:0]      pal_wr_data;
   logic [PAL_ADDR_W-1:0] pal_rd_addr;
   logic [RGB_W-1:0]      pal_rd_data;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_we_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;
   logic [RGB_W-1:0]      rsp_rgb_ff;
   logic                  rsp_last_ff;

   // ---------------------------------------------------------------------
   // Configuration port. Register i lies at byte address 4*i.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_x_ff         <= '0;
         tile_y_ff         <= '0;
         sprite_width_ff   <= SIZE_W'(24);
         sprite_height_ff  <= SIZE_W'(24);
         centered_ff       <= 1'b0;
         palette_select_ff <= PAL_BASE;
      end else if (csr_write) begin
         case (csr_index)
            REG_TILE_X:         tile_x_ff         <= csr_pwdata[TILE_IDX_W-1:0];
            REG_TILE_Y:         tile_y_ff         <= csr_pwdata[TILE_IDX_W-1:0];
            REG_SPRITE_WIDTH:   sprite_width_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_SPRITE_HEIGHT:  sprite_height_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_CENTERED:       centered_ff       <= csr_pwdata[0];
            REG_PALETTE_SELECT: palette_select_ff <= csr_pwdata[SEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TILE_X:         csr_prdata = CSR_DATA_W'(tile_x_ff);
         REG_TILE_Y:         csr_prdata = CSR_DATA_W'(tile_y_ff);
         REG_SPRITE_WIDTH:   csr_prdata = CSR_DATA_W'(sprite_width_ff);
         REG_SPRITE_HEIGHT:  csr_prdata = CSR_DATA_W'(sprite_height_ff);
         REG_CENTERED:       csr_prdata = CSR_DATA_W'(centered_ff);
         REG_PALETTE_SELECT: csr_prdata = CSR_DATA_W'(palette_select_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake. The output register frees when empty or taken; the placement
   // stage advances when empty or when the output register can load it.
   // ---------------------------------------------------------------------
   assign out_load     = !rsp_valid_ff || !rsp_stall;
   assign stage_adv    = !s1_valid_ff || out_load;
   assign req_stall    = !stage_adv;
   assign req_accept   = req_valid && stage_adv;
   assign pixel_accept = req_accept && (req_opcode == OP_PIXEL);

   // ---------------------------------------------------------------------
   // Raster counters. A zero size counts as one; a counter already past the
   // last column or row is treated as being on it.
   // ---------------------------------------------------------------------
   always_comb begin
      width_m1  = (sprite_width_ff  == '0) ? '0 : sprite_width_ff  - SIZE_W'(1);
      height_m1 = (sprite_height_ff == '0) ? '0 : sprite_height_ff - SIZE_W'(1);
      col_end   = (col_ff >= width_m1);
      row_end   = (row_ff >= height_m1);
      last_in   = col_end && row_end;
      col_in    = col_ff;
      row_in    = row_ff;
      if (pixel_accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + SIZE_W'(1);
         end else begin
            col_in = col_ff + SIZE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Palette memory. A write and a pixel read never share a cycle since only
   // one item is accepted per cycle, so no forwarding is needed.
   // ---------------------------------------------------------------------
   assign pal_wr_en   = req_accept && (req_opcode == OP_PALETTE);
   assign pal_wr_data = {req_red_in, 2'b00, req_green_in, 2'b00, req_blue_in, 2'b00};
   assign pal_rd_addr = remap_index(req_colour_index, palette_select_ff);

   psb_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_colour_index),
      .wr_data (pal_wr_data),
      .rd_en   (pixel_accept),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   // ---------------------------------------------------------------------
   // Placement stage: holds the pixel while its palette entry is read.
   // ---------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (stage_adv) begin
         s1_valid_in = pixel_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_accept) begin
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_index_ff <= req_colour_index;
         s1_last_ff  <= last_in;
      end
   end

   psb_place #(
      .TILE_W   (TILE_W),
      .TILE_H   (TILE_H),
      .MAP_COLS (MAP_COLS),
      .MAP_ROWS (MAP_ROWS)
   ) u_place (
      .clock         (clock),
      .tile_x        (tile_x_ff),
      .tile_y        (tile_y_ff),
      .sprite_width  (sprite_width_ff),
      .sprite_height (sprite_height_ff),
      .centered      (centered_ff),
      .column        (s1_col_ff),
      .row           (s1_row_ff),
      .colour_index  (s1_index_ff),
      .result        (place)
   );

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         rsp_we_ff   <= place.write_enable;
         rsp_addr_ff <= place.pixel_address;
         rsp_rgb_ff  <= place.write_enable ? pal_rd_data : '0;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_enable  = rsp_we_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_red_out       = rsp_rgb_ff[RGB_W-1 -: CHAN_OUT_W];
   assign rsp_green_out     = rsp_rgb_ff[2*CHAN_OUT_W-1 -: CHAN_OUT_W];
   assign rsp_blue_out      = rsp_rgb_ff[CHAN_OUT_W-1:0];
   assign rsp_last_pixel    = rsp_last_ff;

`ifndef SYNTH
   // The input side only stalls because a placed pixel cannot move on.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("req_stall raised without a blocked pipeline");

   // The palette is never written and read for a pixel in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(pal_wr_en && pixel_accept))
      else $error("palette write and read overlap");

   // After the final pixel of a sprite both counters are back at zero.
   assert property (@(posedge clock) disable iff (reset)
      (pixel_accept && last_in) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters did not return to zero after the last pixel");

   // A suppressed pixel carries neither address nor color.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_we_ff) |-> (rsp_addr_ff == '0 && rsp_rgb_ff == '0))
      else $error("suppressed pixel carries address or color");

   // No result appears right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

@@ sim/psb_blit_checker.sv @@
// Checker for the blitter: watches each port but csr_prdata, predicts each pixel and compares.
`timescale 1ns / 1ps

module psb_blit_checker #(
   parameter int TILE_W   = psb_pkg::DEF_TILE_W,
   parameter int TILE_H   = psb_pkg::DEF_TILE_H,
   parameter int MAP_COLS = psb_pkg::DEF_MAP_COLS,
   parameter int MAP_ROWS = psb_pkg::DEF_MAP_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [psb_pkg::INDEX_W-1:0]    req_colour_index,
   input  logic [psb_pkg::CHAN_IN_W-1:0]  req_red_in,
   input  logic [psb_pkg::CHAN_IN_W-1:0]  req_green_in,
   input  logic [psb_pkg::CHAN_IN_W-1:0]  req_blue_in,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_write_enable,
   input  logic [psb_pkg::ADDR_W-1:0]     rsp_pixel_address,
   input  logic [psb_pkg::CHAN_OUT_W-1:0] rsp_red_out,
   input  logic [psb_pkg::CHAN_OUT_W-1:0] rsp_green_out,
   input  logic [psb_pkg::CHAN_OUT_W-1:0] rsp_blue_out,
   input  logic                           rsp_last_pixel,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [psb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [psb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending,
   output int                             results_seen,
   output int                             sprite_ends
);
   import psb_pkg::*;

   localparam int IMG_W = MAP_COLS * TILE_W;
   localparam int IMG_H = MAP_ROWS * TILE_H;

   localparam logic [INDEX_W-1:0] STRUCTURE_SLOT [16] = '{
      8'h7f, 8'h7e, 8'h7d, 8'h7c, 8'h7a, 8'h2e, 8'h78, 8'h2f,
      8'h7d, 8'h7c, 8'h7b, 8'h7a, 8'h2a, 8'h79, 8'h78, 8'h78
   };
   localparam logic [INDEX_W-1:0] UNIT_SLOT [16] = '{
      8'ha1, 8'hc8, 8'hc9, 8'hca, 8'hcc, 8'hcd, 8'hce, 8'h0c,
      8'hc9, 8'hca, 8'hcb, 8'hcc, 8'hcd, 8'h73, 8'hc6, 8'h72
   };

   typedef struct packed {
      logic                  write_enable;
      logic [ADDR_W-1:0]     pixel_address;
      logic [CHAN_OUT_W-1:0] red;
      logic [CHAN_OUT_W-1:0] green;
      logic [CHAN_OUT_W-1:0] blue;
      logic                  last_pixel;
   } pixel_result_type;

   pixel_result_type      pixel_due_q [$];
   logic [RGB_W-1:0]      palette_copy [PAL_DEPTH];
   int                    column_at;
   int                    row_at;
   logic [TILE_IDX_W-1:0] tile_x_q;
   logic [TILE_IDX_W-1:0] tile_y_q;
   logic [SIZE_W-1:0]     width_q;
   logic [SIZE_W-1:0]     height_q;
   logic                  centered_q;
   logic [SEL_W-1:0]      select_q;
   int                    mismatches = 0;
   int                    seen = 0;
   int                    ends = 0;

   initial begin
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
      sprite_ends  = 0;
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_result_type want;
      int               span_x, span_y, org_x, org_y, pos_x, pos_y;
      logic [INDEX_W-1:0] slot;
      logic [RGB_W-1:0] rgb;
      if (reset) begin
         column_at  = 0;
         row_at     = 0;
         tile_x_q   = '0;
         tile_y_q   = '0;
         width_q    = 8'd24;
         height_q   = 8'd24;
         centered_q = 1'b0;
         select_q   = PAL_BASE;
         pixel_due_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[4:2]))
               REG_TILE_X:         tile_x_q   = csr_pwdata[TILE_IDX_W-1:0];
               REG_TILE_Y:         tile_y_q   = csr_pwdata[TILE_IDX_W-1:0];
               REG_SPRITE_WIDTH:   width_q    = csr_pwdata[SIZE_W-1:0];
               REG_SPRITE_HEIGHT:  height_q   = csr_pwdata[SIZE_W-1:0];
               REG_CENTERED:       centered_q = csr_pwdata[0];
               REG_PALETTE_SELECT: select_q   = csr_pwdata[SEL_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (rsp_last_pixel) ends++;
            if (pixel_due_q.size() == 0) begin
               $error("result with no pixel waiting: address %0d", rsp_pixel_address);
               mismatches++;
            end else begin
               want = pixel_due_q.pop_front();
               check_field("write_enable", want.write_enable, rsp_write_enable);
               check_field("pixel_address", want.pixel_address, rsp_pixel_address);
               check_field("red_out", want.red, rsp_red_out);
               check_field("green_out", want.green, rsp_green_out);
               check_field("blue_out", want.blue, rsp_blue_out);
               check_field("last_pixel", want.last_pixel, rsp_last_pixel);
            end
         end

         if (req_valid && !req_stall) begin
            if (req_opcode == OP_PALETTE) begin
               palette_copy[req_colour_index] = {req_red_in, 2'b00, req_green_in, 2'b00,
                                                 req_blue_in, 2'b00};
            end else begin
               // A zero size steps like a size of one; centering uses the raw value.
               span_x = (width_q == 0) ? 1 : int'(width_q);
               span_y = (height_q == 0) ? 1 : int'(height_q);
               org_x  = int'(tile_x_q) * TILE_W;
               org_y  = int'(tile_y_q) * TILE_H;
               if (centered_q) begin
                  org_x = org_x - int'(width_q) / 2 + TILE_W / 2;
                  org_y = org_y - int'(height_q) / 2 + TILE_H / 2;
               end
               pos_x = org_x + column_at;
               pos_y = org_y + row_at;
               want  = '0;
               if (req_colour_index != CLEAR_INDEX_A && req_colour_index != CLEAR_INDEX_B &&
                   pos_x >= 0 && pos_x < IMG_W && pos_y >= 0 && pos_y < IMG_H) begin
                  slot = req_colour_index;
                  if (req_colour_index[7:4] == REMAP_BANK) begin
                     if (select_q == PAL_STRUCTURE) slot = STRUCTURE_SLOT[req_colour_index[3:0]];
                     else if (select_q == PAL_UNIT) slot = UNIT_SLOT[req_colour_index[3:0]];
                  end
                  rgb                = palette_copy[slot];
                  want.write_enable  = 1'b1;
                  want.pixel_address = ADDR_W'(pos_y * IMG_W + pos_x);
                  want.red           = rgb[23:16];
                  want.green         = rgb[15:8];
                  want.blue          = rgb[7:0];
               end
               want.last_pixel = (column_at >= span_x - 1) && (row_at >= span_y - 1);
               if (column_at >= span_x - 1) begin
                  column_at = 0;
                  row_at    = (row_at >= span_y - 1) ? 0 : row_at + 1;
               end else begin
                  column_at = column_at + 1;
               end
               pixel_due_q.push_back(want);
            end
         end
      end
      fail_count   <= mismatches;
      pending      <= pixel_due_q.size();
      results_seen <= seen;
      sprite_ends  <= ends;
   end

endmodule

@@ sim/tb_palette_sprite_blitter_core.sv @@
// Stimulus and verdict for the palette sprite blitter, checked by a separate checker.
`timescale 1ns / 1ps

module tb_palette_sprite_blitter_core;
   import psb_pkg::*;

   // Palette select 3 has no name in the package; it behaves as the base palette.
   localparam logic [SEL_W-1:0] PAL_SPARE = 2'd3;

   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 57;
   localparam int HOLD_CYCLES     = 64;
   localparam int DRAIN_LIMIT     = 5000;
   // The pipeline is two stages deep, so a few cycles cover any work still in flight.
   localparam int SETTLE_CYCLES   = 6;
   localparam int END_CYCLES      = 10;

   typedef enum {GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH} gap_mode_type;

   typedef struct {
      logic [TILE_IDX_W-1:0] tile_x;
      logic [TILE_IDX_W-1:0] tile_y;
      logic [SIZE_W-1:0]     width;
      logic [SIZE_W-1:0]     height;
      logic                  centered;
      logic [SEL_W-1:0]      select;
   } blit_setting_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_PALETTE;
   logic [INDEX_W-1:0]    req_colour_index = '0;
   logic [CHAN_IN_W-1:0]  req_red_in = '0;
   logic [CHAN_IN_W-1:0]  req_green_in = '0;
   logic [CHAN_IN_W-1:0]  req_blue_in = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_write_enable;
   logic [ADDR_W-1:0]     rsp_pixel_address;
   logic [CHAN_OUT_W-1:0] rsp_red_out;
   logic [CHAN_OUT_W-1:0] rsp_green_out;
   logic [CHAN_OUT_W-1:0] rsp_blue_out;
   logic                  rsp_last_pixel;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending;
   int results_seen;
   int sprite_ends;

   // Idle rates in percent, set per phase by the main process.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // The main process bumps hold_ticket to ask for one long receiver hold-off;
   // the receiver process alone owns the countdown.
   int hold_ticket = 0;
   int hold_seen   = 0;
   int hold_left   = 0;

   int palette_items = 0;
   int pixel_items   = 0;
   int settings_used = 0;
   bit timed_out     = 1'b0;

   palette_sprite_blitter_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_colour_index  (req_colour_index),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   psb_blit_checker #(
      .TILE_W   (DEF_TILE_W),
      .TILE_H   (DEF_TILE_H),
      .MAP_COLS (DEF_MAP_COLS),
      .MAP_ROWS (DEF_MAP_ROWS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_colour_index  (req_colour_index),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .pending           (pending),
      .results_seen      (results_seen),
      .sprite_ends       (sprite_ends)
   );

   // 20 ns clock period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver side. Outside a hold-off the stall is drawn fresh every cycle.
   // During a hold-off the stall stays high long enough for both pipeline stages to
   // fill and for req_stall to push back on the sender.
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Hard stop in case the block hangs anywhere; far beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("tb_palette_sprite_blitter_core: done, errors");
      $finish;
   end

   task automatic set_gaps(input gap_mode_type mode);
      case (mode)
         GAPS_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         GAPS_SENDER: begin
            send_idle_pct  = 75;
            recv_stall_pct = 0;
         end
         GAPS_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 75;
         end
         default: begin
            send_idle_pct  = 13;
            recv_stall_pct = 13;
         end
      endcase
   endtask

   // Offers one item and returns at the edge where it is accepted. The valid is
   // left high, so a following item without a gap goes out back to back.
   task automatic send_item(input logic op, input logic [INDEX_W-1:0] index,
                            input logic [CHAN_IN_W-1:0] red, input logic [CHAN_IN_W-1:0] green,
                            input logic [CHAN_IN_W-1:0] blue);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_colour_index <= index;
      req_red_in       <= red;
      req_green_in     <= green;
      req_blue_in      <= blue;
      do @(posedge clock); while (req_stall);
      if (op == OP_PALETTE) palette_items++;
      else pixel_items++;
   endtask

   // A pixel item ignores its color fields, so they carry random values.
   task automatic send_pixel(input logic [INDEX_W-1:0] index);
      send_item(OP_PIXEL, index, CHAN_IN_W'($urandom), CHAN_IN_W'($urandom),
                CHAN_IN_W'($urandom));
   endtask

   // Lowers valid and waits until every expected pixel has come out, then lets
   // the pipeline settle so a trailing palette write has landed too.
   task automatic drain(input int settle);
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && !timed_out) begin
         @(posedge clock);
         waited++;
         if (waited > DRAIN_LIMIT) timed_out = 1'b1;
      end
      if (!timed_out) repeat (settle) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access until pready. The select stays
   // high between writes of a batch; the caller lowers it at the end.
   task automatic csr_write(input csr_index_type reg_idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Settings change only while the block is idle. The sprite counters keep
   // whatever position the previous phase left them at, so a shrinking size
   // regularly leaves a counter past the new last column or row.
   task automatic apply_settings(input blit_setting_type s);
      drain(SETTLE_CYCLES);
      csr_write(REG_TILE_X, CSR_DATA_W'(s.tile_x));
      csr_write(REG_TILE_Y, CSR_DATA_W'(s.tile_y));
      csr_write(REG_SPRITE_WIDTH, CSR_DATA_W'(s.width));
      csr_write(REG_SPRITE_HEIGHT, CSR_DATA_W'(s.height));
      csr_write(REG_CENTERED, CSR_DATA_W'(s.centered));
      csr_write(REG_PALETTE_SELECT, CSR_DATA_W'(s.select));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings_used++;
   endtask

   // Mostly small sprites so sprite ends come often, with the odd zero, full
   // size or arbitrary size.
   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(15))
         0:       return 8'd255;
         1:       return 8'd0;
         2:       return SIZE_W'($urandom_range(255));
         default: return SIZE_W'($urandom_range(1, 6));
      endcase
   endfunction

   // Edge cells are favored so that off-image pixels on every side show up.
   function automatic logic [TILE_IDX_W-1:0] pick_tile();
      case ($urandom_range(3))
         0:       return '0;
         1:       return 6'd63;
         default: return TILE_IDX_W'($urandom_range(63));
      endcase
   endfunction

   initial begin : stimulus
      blit_setting_type setting;
      int            phase, n, pick;
      logic [INDEX_W-1:0] index;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole palette first so that no pixel ever reads an unwritten
      // entry, whatever index or remap the random part picks later.
      set_gaps(GAPS_NONE);
      for (n = 0; n < PAL_DEPTH; n++) begin
         send_item(OP_PALETTE, INDEX_W'(n), CHAN_IN_W'($urandom), CHAN_IN_W'($urandom),
                   CHAN_IN_W'($urandom));
      end

      // Directed part. A 3 by 2 centered sprite under the structure remap covers
      // both transparent indices, the ends of the remap range and the top index.
      // The palette writes before and between the pixels must not move the raster
      // counters, and carry all-ones and all-zeros colors.
      set_gaps(GAPS_BOTH);
      setting = '{tile_x: 6'd0, tile_y: 6'd0, width: 8'd3, height: 8'd2, centered: 1'b1,
                  select: PAL_STRUCTURE};
      apply_settings(setting);
      send_item(OP_PALETTE, 8'h2a, 6'd63, 6'd63, 6'd63);
      send_pixel(CLEAR_INDEX_A);
      send_pixel(CLEAR_INDEX_B);
      send_pixel(8'hb0);
      send_item(OP_PALETTE, 8'h7f, 6'd0, 6'd0, 6'd0);
      send_pixel(8'hbf);
      send_item(OP_PALETTE, 8'hff, 6'd63, 6'd0, 6'd63);
      send_pixel(8'hbc);
      send_pixel(8'hff);

      // Full width with zero height, centered on the left edge cell: every pixel
      // lands left of the image. Palette select 3 acts as the base palette.
      setting = '{tile_x: 6'd0, tile_y: 6'd63, width: 8'd255, height: 8'd0, centered: 1'b1,
                  select: PAL_SPARE};
      apply_settings(setting);
      send_pixel(8'hb1);
      send_pixel(8'h01);
      send_pixel(8'h80);

      // Zero width at the bottom right cell under the unit remap. The column
      // counter starts beyond the new last column, so the first pixel already
      // ends the sprite, and so does every one after it.
      setting = '{tile_x: 6'd63, tile_y: 6'd63, width: 8'd0, height: 8'd1, centered: 1'b1,
                  select: PAL_UNIT};
      apply_settings(setting);
      send_pixel(8'hb0);
      send_pixel(8'hb7);
      send_pixel(8'hbf);
      send_pixel(CLEAR_INDEX_B);

      // Largest sprite, top left aligned on the last cell, base palette.
      setting = '{tile_x: 6'd63, tile_y: 6'd63, width: 8'd255, height: 8'd255, centered: 1'b0,
                  select: PAL_BASE};
      apply_settings(setting);
      send_pixel(8'hb3);
      send_pixel(8'h40);

      // Random part: one register setting per phase, idle modes in rotation.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (!timed_out) begin
            setting.tile_x   = pick_tile();
            setting.tile_y   = pick_tile();
            setting.width    = pick_size();
            setting.height   = pick_size();
            setting.centered = 1'($urandom_range(1));
            setting.select   = SEL_W'($urandom_range(3));
            apply_settings(setting);
            set_gaps(gap_mode_type'(phase % 4));
            // In one phase without gaps the receiver holds off for a long
            // stretch while the sender keeps offering items back to back.
            if (phase == 4) hold_ticket++;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
               pick = $urandom_range(99);
               if (pick < 18) begin
                  send_item(OP_PALETTE, INDEX_W'($urandom), CHAN_IN_W'($urandom),
                            CHAN_IN_W'($urandom), CHAN_IN_W'($urandom));
               end else begin
                  case ($urandom_range(9))
                     0, 1, 2: index = 8'hb0 | INDEX_W'($urandom_range(15));
                     3:       index = $urandom_range(1) ? CLEAR_INDEX_A : CLEAR_INDEX_B;
                     default: index = INDEX_W'($urandom);
                  endcase
                  send_pixel(index);
               end
            end
         end
      end

      drain(END_CYCLES);

      $display("Covered %0d palette writes and %0d pixels under %0d register settings,",
               palette_items, pixel_items, settings_used);
      $display("with %0d results compared and %0d sprite ends among them.",
               results_seen, sprite_ends);
      if (!timed_out && fail_count == 0 && pending == 0) begin
         $display("tb_palette_sprite_blitter_core: done, clean");
      end else begin
         $display("tb_palette_sprite_blitter_core: done, errors");
      end
      $finish;
   end

endmodule
